// File: src/ebq_pkg.sv
`timescale 1ns / 1ps

package ebq_pkg;

  localparam int ACC_BITS_DEF  = 32;
  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_STEPS = 2'd1,
    OP_CLEAR = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_LONG_HOLD = 2'd1,
    CFG_EVENT_GAP = 2'd2,
    CFG_CPS       = 2'd3
  } cfg_e;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd20;
  localparam logic [15:0] LONG_HOLD_RST = 16'd600;
  localparam logic [15:0] EVENT_GAP_RST = 16'd150;
  localparam logic [7:0]  CPS_RST       = 8'd4;

  typedef struct packed {
    logic ge;
    logic gt;
  } tcmp_t;

endpackage

// File: src/encoder_button_qualifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   op_i, raw_count_i, button_down_i, now_ms_i
// out       output     out_valid_o / out_ready_i short_press_o, long_press_o, held_o, steps_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Init and clear go straight to done; a poll runs its checks on the shared time comparator.
// Take steps runs the one-bit-per-cycle restoring divider, then clamp, multiply and subtract.
// Take steps with a zero step size skips the divider.
// Reset restores the register defaults and clears all tracking state at once.
// A finished result waits in an internal stage while the output register is full and not taken.

module encoder_button_qualifier import ebq_pkg::*; #(
  parameter int ACC_BITS  = ACC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] raw_count_i,
  input  logic               button_down_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               short_press_o,
  output logic               long_press_o,
  output logic               held_o,
  output logic signed [31:0] steps_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int QW = (ACC_BITS > 32) ? ACC_BITS : 32;
  localparam int MW = (ACC_BITS > 41) ? ACC_BITS : 41;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEB   = 4'd1;
  localparam logic [3:0] S_REL   = 4'd2;
  localparam logic [3:0] S_HOLD  = 4'd3;
  localparam logic [3:0] S_GAP   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_SUB   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [QW-1:0] Q_MAX = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-64'sd2147483648);

  logic [3:0] state_q, state_d;

  logic [15:0] debounce_q, long_hold_q, event_gap_q;
  logic [7:0]  cps_q;

  logic signed [15:0]         prev_count_q;
  logic signed [ACC_BITS-1:0] step_total_q;
  logic                       prev_level_q, stable_q;
  logic [TIME_BITS-1:0]       change_time_q, press_start_q, event_time_q, now_q;
  logic                       press_active_q, long_done_q, swallow_q;

  logic                       sp_q, lp_q, neg_q;
  logic signed [31:0]         steps_q, qsat_q;
  logic signed [ACC_BITS-1:0] prod_q;

  logic               out_valid_q, out_sp_q, out_lp_q, out_held_q;
  logic signed [31:0] out_steps_q;

  logic                       in_fire, out_free, hold_ok;
  logic [TIME_BITS-1:0]       now_t, tc_then;
  logic [15:0]                tc_thr;
  tcmp_t                      tc;
  logic signed [15:0]         delta;
  logic signed [ACC_BITS:0]   acc_sum;
  logic signed [ACC_BITS-1:0] acc_sat, q_full;
  logic signed [QW-1:0]       q_ext;
  logic signed [31:0]         q_clamp;
  logic signed [40:0]         prod_w;
  logic [ACC_BITS-1:0]        div_dividend, div_quo;
  logic                       div_start, div_done;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign now_t       = TIME_BITS'(now_ms_i);

  assign delta   = raw_count_i - prev_count_q;
  assign acc_sum = {step_total_q[ACC_BITS-1], step_total_q} + (ACC_BITS+1)'(delta);
  assign acc_sat = (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1]) ?
                   (acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_BITS-1:0];

  always_comb begin
    case (state_q)
      S_REL, S_GAP: begin
        tc_then = event_time_q;
        tc_thr  = event_gap_q;
      end
      S_HOLD: begin
        tc_then = press_start_q;
        tc_thr  = long_hold_q;
      end
      default: begin
        tc_then = change_time_q;
        tc_thr  = debounce_q;
      end
    endcase
  end

  ebq_time_cmp #(.TIME_BITS(TIME_BITS)) u_time_cmp (
    .now_i  (now_q),
    .then_i (tc_then),
    .thr_i  (tc_thr),
    .res_o  (tc)
  );

  assign div_start    = in_fire && (op_i == OP_STEPS) && (cps_q != 8'd0);
  assign div_dividend = step_total_q[ACC_BITS-1] ? -step_total_q : step_total_q;

  ebq_divider #(.ACC_BITS(ACC_BITS)) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cps_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign q_full  = neg_q ? -$signed(div_quo) : $signed(div_quo);
  assign q_ext   = QW'(q_full);
  assign q_clamp = (q_ext > Q_MAX) ? 32'sh7FFF_FFFF :
                   (q_ext < Q_MIN) ? 32'sh8000_0000 : q_ext[31:0];
  assign prod_w  = qsat_q * $signed({1'b0, cps_q});

  assign hold_ok = stable_q && !long_done_q && !swallow_q && press_active_q && tc.ge;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (op_i)
            OP_POLL:  state_d = S_DEB;
            OP_STEPS: state_d = (cps_q != 8'd0) ? S_DIV : S_DONE;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_DEB: begin
        if (!tc.ge) begin
          state_d = S_DONE;
        end else if ((stable_q != prev_level_q) && !prev_level_q) begin
          state_d = S_REL;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_REL:   state_d = S_HOLD;
      S_HOLD:  state_d = hold_ok ? S_GAP : S_DONE;
      S_GAP:   state_d = S_DONE;
      S_DIV:   state_d = div_done ? S_CLAMP : S_DIV;
      S_CLAMP: state_d = S_MUL;
      S_MUL:   state_d = S_SUB;
      S_SUB:   state_d = S_DONE;
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      long_hold_q <= LONG_HOLD_RST;
      event_gap_q <= EVENT_GAP_RST;
      cps_q       <= CPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        CFG_LONG_HOLD: long_hold_q <= cfg_data_i;
        CFG_EVENT_GAP: event_gap_q <= cfg_data_i;
        CFG_CPS:       cps_q       <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q   <= '0;
      step_total_q   <= '0;
      prev_level_q   <= 1'b0;
      stable_q       <= 1'b0;
      change_time_q  <= '0;
      press_start_q  <= '0;
      event_time_q   <= '0;
      press_active_q <= 1'b0;
      long_done_q    <= 1'b0;
      swallow_q      <= 1'b0;
      now_q          <= '0;
      sp_q           <= 1'b0;
      lp_q           <= 1'b0;
      neg_q          <= 1'b0;
      steps_q        <= '0;
      qsat_q         <= '0;
      prod_q         <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            now_q   <= now_t;
            sp_q    <= 1'b0;
            lp_q    <= 1'b0;
            steps_q <= '0;
            neg_q   <= step_total_q[ACC_BITS-1];
            case (op_i)
              OP_POLL: begin
                prev_count_q <= raw_count_i;
                step_total_q <= acc_sat;
                if (button_down_i != prev_level_q) begin
                  prev_level_q  <= button_down_i;
                  change_time_q <= now_t;
                end
              end
              OP_CLEAR: begin
                step_total_q   <= '0;
                press_start_q  <= '0;
                press_active_q <= 1'b0;
                long_done_q    <= 1'b0;
                change_time_q  <= now_t;
                if (!stable_q) begin
                  prev_level_q <= 1'b0;
                  swallow_q    <= 1'b0;
                end else begin
                  swallow_q <= 1'b1;
                end
              end
              OP_INIT: begin
                prev_count_q  <= raw_count_i;
                prev_level_q  <= button_down_i;
                stable_q      <= button_down_i;
                change_time_q <= now_t;
              end
              default: ;
            endcase
          end
        end
        S_DEB: begin
          if (tc.ge && (stable_q != prev_level_q) && prev_level_q) begin
            stable_q       <= 1'b1;
            press_start_q  <= now_q;
            press_active_q <= 1'b1;
            long_done_q    <= 1'b0;
          end
        end
        S_REL: begin
          stable_q <= 1'b0;
          if (swallow_q) begin
            swallow_q <= 1'b0;
          end else if (press_active_q && !long_done_q && tc.gt) begin
            sp_q         <= 1'b1;
            event_time_q <= now_q;
          end
          press_start_q  <= '0;
          press_active_q <= 1'b0;
          long_done_q    <= 1'b0;
        end
        S_GAP: begin
          if (tc.gt) begin
            lp_q         <= 1'b1;
            long_done_q  <= 1'b1;
            swallow_q    <= 1'b1;
            event_time_q <= now_q;
          end
        end
        S_CLAMP: begin
          qsat_q  <= q_clamp;
          steps_q <= q_clamp;
        end
        S_MUL: begin
          prod_q <= ACC_BITS'(MW'(prod_w));
        end
        S_SUB: begin
          step_total_q <= step_total_q - prod_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_sp_q    <= 1'b0;
      out_lp_q    <= 1'b0;
      out_held_q  <= 1'b0;
      out_steps_q <= '0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_sp_q    <= sp_q;
        out_lp_q    <= lp_q;
        out_held_q  <= stable_q;
        out_steps_q <= steps_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign short_press_o = out_sp_q;
  assign long_press_o  = out_lp_q;
  assign held_o        = out_held_q;
  assign steps_o       = out_steps_q;

endmodule

// File: src/ebq_time_cmp.sv
`timescale 1ns / 1ps

module ebq_time_cmp import ebq_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] then_i,
  input  logic [15:0]          thr_i,
  output tcmp_t                res_o
);

  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] thr_ext;

  assign elapsed    = now_i - then_i;
  assign thr_ext    = TIME_BITS'(thr_i);
  assign res_o.ge   = (elapsed >= thr_ext);
  assign res_o.gt   = (elapsed >= thr_ext) && (elapsed != thr_ext);

endmodule

// File: src/ebq_divider.sv
`timescale 1ns / 1ps

module ebq_divider import ebq_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ACC_BITS-1:0] dividend_i,
  input  logic [7:0]          divisor_i,
  output logic                done_o,
  output logic [ACC_BITS-1:0] quotient_o
);

  localparam int CW = $clog2(ACC_BITS);

  logic                busy_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  logic [ACC_BITS-1:0] num_q;
  logic [ACC_BITS-1:0] quo_q;
  logic [7:0]          rem_q;
  logic [7:0]          div_q;
  logic [8:0]          rem_sh;
  logic [8:0]          rem_sub;
  logic                fits;

  assign rem_sh  = {rem_q, num_q[ACC_BITS-1]};
  assign fits    = (rem_sh >= {1'b0, div_q});
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= dividend_i;
        quo_q  <= '0;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        num_q <= {num_q[ACC_BITS-2:0], 1'b0};
        quo_q <= {quo_q[ACC_BITS-2:0], fits};
        rem_q <= fits ? rem_sub[7:0] : rem_sh[7:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ACC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/ebq_checker.sv
`timescale 1ns / 1ps

module ebq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               short_press_o,
  input logic               long_press_o,
  input logic               held_o,
  input logic signed [31:0] steps_o
);

  // A stalled result keeps its step count until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(steps_o))
    else $error("output changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(short_press_o && long_press_o))
    else $error("short and long press in one result");

  a_steps_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (steps_o != 32'sd0) |-> !short_press_o && !long_press_o)
    else $error("press event with nonzero steps");

  a_press_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!long_press_o || held_o) && (!short_press_o || !held_o))
    else $error("press event disagrees with held level");

endmodule

bind encoder_button_qualifier ebq_checker u_ebq_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ebq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam longint ACC_MAX = (longint'(1) << (ACC_BITS_DEF - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint STEP_MAX = 64'sd2147483647;
  localparam longint STEP_MIN = -64'sd2147483648;

  typedef struct packed {
    logic               short_press;
    logic               long_press;
    logic               held;
    logic signed [31:0] steps;
  } report_t;

  class press_scoreboard;
    bit [15:0]   settle_ms;
    bit [15:0]   hold_ms;
    bit [15:0]   gap_ms;
    bit [7:0]    step_div;
    bit [15:0]   last_count;
    longint      step_acc;
    bit          raw_level;
    bit          stable_level;
    bit          press_active;
    bit          long_done;
    bit          swallow_release;
    bit [31:0]   change_ms;
    bit [31:0]   press_ms;
    bit [31:0]   event_ms;
    report_t     expected_reports[$];
    int unsigned error_count;
    int unsigned reports_checked;
    int unsigned shorts_seen;
    int unsigned longs_seen;

    function new();
      settle_ms = DEBOUNCE_RST;
      hold_ms   = LONG_HOLD_RST;
      gap_ms    = EVENT_GAP_RST;
      step_div  = CPS_RST;
      step_acc  = 0;
    endfunction

    function void write_reg(cfg_e idx, bit [15:0] data);
      case (idx)
        CFG_DEBOUNCE:  settle_ms = data;
        CFG_LONG_HOLD: hold_ms = data;
        CFG_EVENT_GAP: gap_ms = data;
        CFG_CPS:       step_div = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void qualify_item(op_e op, bit [15:0] raw, bit level, bit [31:0] now);
      report_t         r;
      bit signed [15:0] delta;
      bit [31:0]       since_change;
      bit [31:0]       since_press;
      bit [31:0]       since_event;
      longint          divisor;
      longint          q;
      r = '0;
      case (op)
        OP_POLL: begin
          delta = raw - last_count;
          last_count = raw;
          step_acc = step_acc + delta;
          if (step_acc > ACC_MAX) begin
            step_acc = ACC_MAX;
          end else if (step_acc < ACC_MIN) begin
            step_acc = ACC_MIN;
          end
          if (level != raw_level) begin
            raw_level = level;
            change_ms = now;
          end
          since_change = now - change_ms;
          if (since_change >= settle_ms) begin
            if (stable_level != raw_level) begin
              stable_level = raw_level;
              if (stable_level) begin
                press_ms = now;
                press_active = 1'b1;
                long_done = 1'b0;
              end else begin
                since_event = now - event_ms;
                if (swallow_release) begin
                  swallow_release = 1'b0;
                end else if (press_active && !long_done && since_event > gap_ms) begin
                  r.short_press = 1'b1;
                  event_ms = now;
                end
                press_ms = '0;
                press_active = 1'b0;
                long_done = 1'b0;
              end
            end
            since_press = now - press_ms;
            since_event = now - event_ms;
            if (stable_level && !long_done && !swallow_release && press_active &&
                since_press >= hold_ms && since_event > gap_ms) begin
              r.long_press = 1'b1;
              long_done = 1'b1;
              swallow_release = 1'b1;
              event_ms = now;
            end
          end
        end
        OP_STEPS: begin
          divisor = step_div;
          if (divisor != 0) begin
            q = step_acc / divisor;
            if (q > STEP_MAX) begin
              q = STEP_MAX;
            end else if (q < STEP_MIN) begin
              q = STEP_MIN;
            end
            step_acc = step_acc - q * divisor;
            r.steps = q[31:0];
          end
        end
        OP_CLEAR: begin
          step_acc = 0;
          press_ms = '0;
          press_active = 1'b0;
          long_done = 1'b0;
          change_ms = now;
          if (!stable_level) begin
            raw_level = 1'b0;
            swallow_release = 1'b0;
          end else begin
            swallow_release = 1'b1;
          end
        end
        OP_INIT: begin
          last_count = raw;
          raw_level = level;
          stable_level = level;
          change_ms = now;
        end
        default: ;
      endcase
      r.held = stable_level;
      expected_reports.push_back(r);
    endfunction

    function void check_report(logic sp, logic lp, logic hd, logic signed [31:0] st);
      report_t want;
      if (expected_reports.size() == 0) begin
        $error("Report with no item waiting: held %0d, steps %0d", hd, st);
        error_count++;
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      if (sp !== want.short_press) begin
        $error("short_press: expected %0d, got %0d", want.short_press, sp);
        error_count++;
      end
      if (lp !== want.long_press) begin
        $error("long_press: expected %0d, got %0d", want.long_press, lp);
        error_count++;
      end
      if (hd !== want.held) begin
        $error("held: expected %0d, got %0d", want.held, hd);
        error_count++;
      end
      if (st !== want.steps) begin
        $error("steps: expected %0d, got %0d", want.steps, st);
        error_count++;
      end
      if (sp === 1'b1) shorts_seen++;
      if (lp === 1'b1) longs_seen++;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i = OP_POLL;
  logic signed [15:0] raw_count_i = '0;
  logic               button_down_i = 1'b0;
  logic [31:0]        now_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               short_press_o;
  logic               long_press_o;
  logic               held_o;
  logic signed [31:0] steps_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_DEBOUNCE;
  logic [15:0]        cfg_data_i = '0;

  press_scoreboard sb;
  bit              idle_on;
  bit [31:0]       cur_ms;
  bit [15:0]       cur_count;
  int unsigned     items_sent;
  int unsigned     settings_used;
  int unsigned     cycle_count;

  encoder_button_qualifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .raw_count_i  (raw_count_i),
    .button_down_i(button_down_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .short_press_o(short_press_o),
    .long_press_o (long_press_o),
    .held_o       (held_o),
    .steps_o      (steps_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_report(short_press_o, long_press_o, held_o, steps_o);
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_on && $urandom_range(0, 6) == 0) begin
          stall_left = $urandom_range(1, 13);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  task automatic send_item(op_e op, bit [15:0] raw, bit level, bit [31:0] now);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    raw_count_i   <= raw;
    button_down_i <= level;
    now_ms_i      <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.qualify_item(op, raw, level, now);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(cfg_e idx, bit [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(bit [15:0] debounce, bit [15:0] hold, bit [15:0] gap,
                           bit [15:0] cps);
    wait_for_reports();
    write_cfg(CFG_DEBOUNCE, debounce);
    write_cfg(CFG_LONG_HOLD, hold);
    write_cfg(CFG_EVENT_GAP, gap);
    write_cfg(CFG_CPS, cps);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic poll_once(bit level, int unsigned dt_max);
    if ($urandom_range(0, 49) == 0) begin
      cur_ms += $urandom;
    end else begin
      cur_ms += $urandom_range(0, dt_max);
    end
    if ($urandom_range(0, 29) == 0) begin
      cur_count = 16'($urandom);
    end else begin
      cur_count += 16'($urandom_range(0, 16) - 8);
    end
    send_item(OP_POLL, cur_count, level, cur_ms);
  endtask

  task automatic press_gesture(int unsigned dt_max);
    int unsigned hold_polls;
    int unsigned rest_polls;
    hold_polls = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 15);
    rest_polls = $urandom_range(1, 15);
    repeat ($urandom_range(0, 3)) poll_once(1'($urandom), dt_max);
    repeat (hold_polls) poll_once(1'b1, dt_max);
    repeat ($urandom_range(0, 3)) poll_once(1'($urandom), dt_max);
    repeat (rest_polls) poll_once(1'b0, dt_max);
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned dt_max);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < n_items) begin
      case ($urandom_range(0, 11))
        0: send_item(op_e'($urandom_range(0, 3)), 16'($urandom), 1'($urandom), $urandom);
        1: send_item(OP_STEPS, 16'($urandom), 1'($urandom), cur_ms);
        2: send_item(OP_CLEAR, 16'($urandom), 1'($urandom), cur_ms);
        3: begin
          cur_count = 16'($urandom);
          send_item(OP_INIT, cur_count, 1'($urandom), cur_ms);
        end
        4: begin
          if ($urandom_range(0, 2) == 0) begin
            wait_for_reports();
          end else begin
            send_item(OP_STEPS, cur_count, 1'b0, cur_ms);
          end
        end
        default: press_gesture(dt_max);
      endcase
    end
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(OP_INIT,  16'h8000, 1'b0, 32'hFFFF_FF00);
    send_item(OP_POLL,  16'h7FFF, 1'b0, 32'hFFFF_FF05);
    send_item(OP_POLL,  16'h8000, 1'b1, 32'hFFFF_FFEC);
    send_item(OP_POLL,  16'h8007, 1'b1, 32'd0);
    send_item(OP_POLL,  16'h8007, 1'b1, 32'd599);
    send_item(OP_POLL,  16'h8007, 1'b1, 32'd600);
    send_item(OP_POLL,  16'h8007, 1'b0, 32'd700);
    send_item(OP_POLL,  16'h8007, 1'b0, 32'd720);
    send_item(OP_STEPS, 16'h0000, 1'b0, 32'd725);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd730);
    send_item(OP_STEPS, 16'hFFFF, 1'b1, 32'd735);
    send_item(OP_POLL,  16'h7FFD, 1'b1, 32'd1000);
    send_item(OP_POLL,  16'h7FFD, 1'b1, 32'd1020);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd1100);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd1120);
    send_item(OP_POLL,  16'h7FFD, 1'b1, 32'd1130);
    send_item(OP_POLL,  16'h7FFD, 1'b1, 32'd1150);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd1160);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd1180);
    send_item(OP_POLL,  16'h7FFD, 1'b1, 32'd1300);
    send_item(OP_POLL,  16'h7FFD, 1'b1, 32'd1320);
    send_item(OP_CLEAR, 16'h0000, 1'b0, 32'd1330);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd1400);
    send_item(OP_POLL,  16'h7FFD, 1'b0, 32'd1420);
    wait_for_reports();

    // Step the count by the largest forward and backward jumps.
    idle_on = 1'b0;
    cur_ms = 32'd5000;
    send_item(OP_INIT, 16'h0000, 1'b0, cur_ms);
    for (int unsigned k = 1; k <= 12; k++) begin
      send_item(OP_POLL, 16'(k * 32767), 1'b0, cur_ms);
    end
    send_item(OP_STEPS, 16'h0000, 1'b0, cur_ms);
    send_item(OP_CLEAR, 16'h0000, 1'b0, cur_ms);
    send_item(OP_INIT, 16'h0000, 1'b0, cur_ms);
    for (int unsigned k = 1; k <= 12; k++) begin
      send_item(OP_POLL, 16'(k * 32768), 1'b0, cur_ms);
    end
    send_item(OP_STEPS, 16'h0000, 1'b0, cur_ms);
    cur_count = 16'h0000;
    idle_on = 1'b1;

    configure(16'd5, 16'd60, 16'd20, 16'd4);
    random_phase(160, 8);
    configure(16'd0, 16'd0, 16'd0, 16'd1);
    random_phase(160, 3);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(160, 20000);
    configure(16'd2, 16'd25, 16'd0, 16'hFF00);
    random_phase(160, 4);
    idle_on = 1'b0;
    configure(16'd10, 16'd100, 16'd50, 16'd3);
    random_phase(160, 12);

    wait_for_reports();
    repeat (50) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected reports never arrived", sb.pending());
      sb.error_count++;
    end
    $display("Run summary: %0d items under %0d register settings, %0d reports checked.",
             items_sent, settings_used + 1, sb.reports_checked);
    $display("Run summary: %0d short and %0d long presses seen, largest count jumps both ways.",
             sb.shorts_seen, sb.longs_seen);
    if (sb.error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ebq_pkg.sv
src/ebq_time_cmp.sv
src/ebq_divider.sv
src/encoder_button_qualifier.sv
src/ebq_checker.sv
tb/tb_top.sv
